// File: src/grouped_fifo_team_queue_core_macros.svh
// Assertion macros shared by the team queue checker
`ifndef GROUPED_FIFO_TEAM_QUEUE_CORE_MACROS_SVH
`define GROUPED_FIFO_TEAM_QUEUE_CORE_MACROS_SVH

// Implication in the same cycle, quiet while in reset
`define GFTQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle, quiet while in reset
`define GFTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle, checked through reset as well
`define GFTQ_ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/gftq_pkg.sv
// Types and constants of the grouped FIFO team queue
package gftq_pkg;

  localparam int TEAMS       = 16;
  localparam int TEAM_DEPTH  = 64;
  localparam int MEMBER_BITS = 20;

  localparam int TEAM_W   = 4;                          // width of the team_index field
  localparam int RING_W   = $clog2(TEAMS);
  localparam int PTR_W    = $clog2(TEAM_DEPTH);
  localparam int CNT_W    = $clog2(TEAM_DEPTH + 1);
  localparam int OCNT_W   = $clog2(TEAMS + 1);
  localparam int ADDR_W   = RING_W + PTR_W;
  localparam int STORE_N  = TEAMS * TEAM_DEPTH;

  localparam logic [TEAM_W:0]  TEAM_LIMIT = (TEAM_W + 1)'(TEAMS);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(TEAM_DEPTH);
  localparam logic [OCNT_W-1:0] RING_CNT  = OCNT_W'(TEAMS);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(TEAM_DEPTH - 1);
  localparam logic [RING_W-1:0] RING_LAST = RING_W'(TEAMS - 1);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_EMPTY   = 2'd2
  } status_t;

  typedef struct packed {
    logic [0:0]  operation;
    logic [19:0] member_id;
    logic [3:0]  team_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] served_member;
    logic [3:0]  served_team;
  } out_item_t;

endpackage

// File: src/grouped_fifo_team_queue_core.sv
// Grouped FIFO team queue: per-team FIFOs in one member store, served in team arrival order
//
//   channel | ports                        | transaction
//   --------+------------------------------+---------------------------------------
//   command | start, busy, in_item         | start high while busy low
//   result  | out_strobe, out_item         | one cycle per strobe, never held off
//
// One command per cycle; its result appears on the cycle after acceptance,
// set by the registered read of the member store on a dequeue.
// busy stays low: team pointers and the order ring sit in flip-flops and are
// updated at acceptance, so the next command sees them at once.
// Synchronous reset clears all pointers and counts; the member store is not cleared.
// The result side cannot stall.
module grouped_fifo_team_queue_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  gftq_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output gftq_pkg::out_item_t  out_item
);

  logic [gftq_pkg::PTR_W-1:0]  team_head_r [gftq_pkg::TEAMS];
  logic [gftq_pkg::PTR_W-1:0]  team_tail_r [gftq_pkg::TEAMS];
  logic [gftq_pkg::CNT_W-1:0]  team_count_r [gftq_pkg::TEAMS];
  logic [gftq_pkg::RING_W-1:0] order_ring_r [gftq_pkg::TEAMS];
  logic [gftq_pkg::RING_W-1:0] order_head_r, order_head_nxt;
  logic [gftq_pkg::RING_W-1:0] order_tail_r, order_tail_nxt;
  logic [gftq_pkg::OCNT_W-1:0] order_count_r, order_count_nxt;

  logic [gftq_pkg::MEMBER_BITS-1:0] member_store [gftq_pkg::STORE_N];
  logic [gftq_pkg::MEMBER_BITS-1:0] mem_rd_r;

  logic                        out_strobe_r;
  gftq_pkg::status_t           out_status_r;
  logic [gftq_pkg::TEAM_W-1:0] out_team_r;
  logic                        out_deq_ok_r;

  logic                        accept;
  logic [gftq_pkg::RING_W-1:0] enq_team;
  logic [gftq_pkg::RING_W-1:0] front_team;
  gftq_pkg::status_t           status;
  logic                        deq_ok;

  // team table write port
  logic                        team_we;
  logic [gftq_pkg::RING_W-1:0] team_idx;
  logic [gftq_pkg::PTR_W-1:0]  team_head_val;
  logic [gftq_pkg::PTR_W-1:0]  team_tail_val;
  logic [gftq_pkg::CNT_W-1:0]  team_count_val;
  logic                        ring_we;

  // member store ports
  logic                        mem_we;
  logic                        mem_re;
  logic [gftq_pkg::ADDR_W-1:0] mem_addr;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign enq_team   = in_item.team_index[gftq_pkg::RING_W-1:0];
  assign front_team = order_ring_r[order_head_r];

  always_comb begin
    status          = gftq_pkg::STATUS_DONE;
    deq_ok          = 1'b0;
    team_we         = 1'b0;
    team_idx        = enq_team;
    team_head_val   = team_head_r[enq_team];
    team_tail_val   = team_tail_r[enq_team];
    team_count_val  = team_count_r[enq_team];
    ring_we         = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = {enq_team, team_tail_r[enq_team]};
    order_head_nxt  = order_head_r;
    order_tail_nxt  = order_tail_r;
    order_count_nxt = order_count_r;

    if (accept && gftq_pkg::op_t'(in_item.operation) == gftq_pkg::OP_ENQ) begin
      if ({1'b0, in_item.team_index} >= gftq_pkg::TEAM_LIMIT ||
          team_count_r[enq_team] >= gftq_pkg::DEPTH_CNT) begin
        status = gftq_pkg::STATUS_DROPPED;
      end else begin
        mem_we         = 1'b1;
        team_we        = 1'b1;
        team_tail_val  = (team_tail_r[enq_team] == gftq_pkg::PTR_LAST) ? '0
                         : team_tail_r[enq_team] + 1'b1;
        team_count_val = team_count_r[enq_team] + 1'b1;
        // an empty team joins the back of the order ring
        if (team_count_r[enq_team] == '0 && order_count_r < gftq_pkg::RING_CNT) begin
          ring_we         = 1'b1;
          order_tail_nxt  = (order_tail_r == gftq_pkg::RING_LAST) ? '0 : order_tail_r + 1'b1;
          order_count_nxt = order_count_r + 1'b1;
        end
      end
    end else if (accept) begin
      team_idx       = front_team;
      team_head_val  = team_head_r[front_team];
      team_tail_val  = team_tail_r[front_team];
      team_count_val = team_count_r[front_team];
      mem_addr       = {front_team, team_head_r[front_team]};
      if (order_count_r == '0 || team_count_r[front_team] == '0) begin
        status = gftq_pkg::STATUS_EMPTY;
      end else begin
        deq_ok         = 1'b1;
        mem_re         = 1'b1;
        team_we        = 1'b1;
        team_head_val  = (team_head_r[front_team] == gftq_pkg::PTR_LAST) ? '0
                         : team_head_r[front_team] + 1'b1;
        team_count_val = team_count_r[front_team] - 1'b1;
        // drop the team from the ring once its last member leaves
        if (team_count_r[front_team] == gftq_pkg::CNT_W'(1)) begin
          order_head_nxt  = (order_head_r == gftq_pkg::RING_LAST) ? '0 : order_head_r + 1'b1;
          order_count_nxt = order_count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gftq_pkg::TEAMS; i++) begin
        team_head_r[i]  <= '0;
        team_tail_r[i]  <= '0;
        team_count_r[i] <= '0;
      end
      order_head_r  <= '0;
      order_tail_r  <= '0;
      order_count_r <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      if (team_we) begin
        team_head_r[team_idx]  <= team_head_val;
        team_tail_r[team_idx]  <= team_tail_val;
        team_count_r[team_idx] <= team_count_val;
      end
      order_head_r  <= order_head_nxt;
      order_tail_r  <= order_tail_nxt;
      order_count_r <= order_count_nxt;
      out_strobe_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      order_ring_r[order_tail_r] <= enq_team;
    end
    if (accept) begin
      out_status_r <= status;
      out_team_r   <= deq_ok ? gftq_pkg::TEAM_W'(front_team) : '0;
      out_deq_ok_r <= deq_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      member_store[mem_addr] <= in_item.member_id[gftq_pkg::MEMBER_BITS-1:0];
    end
    if (mem_re) begin
      mem_rd_r <= member_store[mem_addr];
    end
  end

  assign out_strobe             = out_strobe_r;
  assign out_item.status        = out_status_r;
  assign out_item.served_member = out_deq_ok_r ? 20'(mem_rd_r) : '0;
  assign out_item.served_team   = out_team_r;

endmodule

// File: src/gftq_checker.sv
// Port checker for the team queue core and its bind
`include "grouped_fifo_team_queue_core_macros.svh"

module gftq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input gftq_pkg::in_item_t  in_item,
  input logic                out_strobe,
  input gftq_pkg::out_item_t out_item
);

  logic accept;
  logic enq_accept;
  logic fail_result;
  logic served_zero;
  logic enq_answer;

  assign accept      = start && !busy;
  assign enq_accept  = accept && in_item.operation == gftq_pkg::OP_ENQ;
  assign fail_result = out_strobe && out_item.status != gftq_pkg::STATUS_DONE;
  assign served_zero = out_item.served_member == '0 && out_item.served_team == '0;
  assign enq_answer  = out_item.status != gftq_pkg::STATUS_EMPTY &&
                       out_item.served_member == '0;

  `GFTQ_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, out_strobe)
  `GFTQ_ASSERT_NEXT(a_no_spurious, clk, rst_n, !accept, !out_strobe)
  `GFTQ_ASSERT_NOW(a_fail_zero, clk, rst_n, fail_result, served_zero)
  `GFTQ_ASSERT_NEXT(a_enq_status, clk, rst_n, enq_accept, enq_answer)
  `GFTQ_ASSERT_NEXT_ANY(a_reset_quiet, clk, !rst_n, !out_strobe)

endmodule

bind grouped_fifo_team_queue_core gftq_checker u_gftq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// File: verif/team_queue_checker.sv
// Checker for the team queue: predicts each command's result and compares it on the strobe
module team_queue_checker
  import gftq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_strobe,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        results_owed
);

  logic [MEMBER_BITS-1:0] member_mem [STORE_N];
  logic [PTR_W-1:0]       team_rd    [TEAMS];
  logic [PTR_W-1:0]       team_wr    [TEAMS];
  logic [CNT_W-1:0]       team_fill  [TEAMS];
  logic [TEAM_W-1:0]      ring_team  [TEAMS];
  logic [RING_W-1:0]      ring_rd;
  logic [RING_W-1:0]      ring_wr;
  logic [OCNT_W-1:0]      ring_fill;
  out_item_t              owed_results [$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  // Apply one command to the predicted queue state and return its result
  function automatic out_item_t serve_command(input in_item_t cmd);
    out_item_t         res;
    logic [TEAM_W-1:0] t;
    logic [ADDR_W-1:0] slot;
    res = '0;
    res.status = STATUS_DONE;
    if (cmd.operation == OP_ENQ) begin
      t = cmd.team_index;
      if ({1'b0, t} >= TEAM_LIMIT || team_fill[t] >= DEPTH_CNT) begin
        res.status = STATUS_DROPPED;
      end else begin
        slot = {t, team_wr[t]};
        member_mem[slot] = cmd.member_id[MEMBER_BITS-1:0];
        team_wr[t] = (team_wr[t] == PTR_LAST) ? '0 : team_wr[t] + 1'b1;
        // a team joins the order ring only when its FIFO was empty
        if (team_fill[t] == '0 && ring_fill < RING_CNT) begin
          ring_team[ring_wr] = t;
          ring_wr = (ring_wr == RING_LAST) ? '0 : ring_wr + 1'b1;
          ring_fill = ring_fill + 1'b1;
        end
        team_fill[t] = team_fill[t] + 1'b1;
      end
    end else if (ring_fill == '0) begin
      res.status = STATUS_EMPTY;
    end else begin
      t = ring_team[ring_rd];
      if ({1'b0, t} < TEAM_LIMIT && team_fill[t] != '0) begin
        slot = {t, team_rd[t]};
        res.served_member = member_mem[slot];
        res.served_team   = t;
        team_rd[t] = (team_rd[t] == PTR_LAST) ? '0 : team_rd[t] + 1'b1;
        team_fill[t] = team_fill[t] - 1'b1;
        // retire the team from the ring once its FIFO runs dry
        if (team_fill[t] == '0) begin
          ring_rd = (ring_rd == RING_LAST) ? '0 : ring_rd + 1'b1;
          ring_fill = ring_fill - 1'b1;
        end
      end else begin
        res.status = STATUS_EMPTY;
      end
    end
    return res;
  endfunction

  task automatic log_failure(input string why);
    if (mismatch_count < 10) $display("[%0t] team queue: %s", $time, why);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch_channels
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < TEAMS; i++) begin
        team_rd[i]   = '0;
        team_wr[i]   = '0;
        team_fill[i] = '0;
      end
      ring_rd   = '0;
      ring_wr   = '0;
      ring_fill = '0;
      owed_results.delete();
    end else begin
      if (out_strobe) begin
        if (owed_results.size() == 0) begin
          log_failure($sformatf("unexpected result status %0d member %h team %0d",
                                out_item.status, out_item.served_member,
                                out_item.served_team));
        end else begin
          want = owed_results.pop_front();
          if (want.status != out_item.status ||
              want.served_member != out_item.served_member ||
              want.served_team != out_item.served_team) begin
            log_failure($sformatf(
              "expected status %0d member %h team %0d, got status %0d member %h team %0d",
              want.status, want.served_member, want.served_team,
              out_item.status, out_item.served_member, out_item.served_team));
          end
        end
      end
      if (start && !busy) owed_results.insert(owed_results.size(), serve_command(in_item));
    end
    results_owed <= owed_results.size();
  end

endmodule

// File: verif/tb_grouped_fifo_team_queue_core.sv
// Testbench top for the team queue core: stimulus, watchdog and verdict
module tb_grouped_fifo_team_queue_core;
  import gftq_pkg::*;

  localparam int IN_W         = $bits(in_item_t);
  localparam int RANDOM_ITEMS = 850;
  localparam int STALL_LIMIT  = 400;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;
  int        mismatch_total;
  int        results_owed;
  int        idle_cycles = 0;
  int        items_sent  = 0;
  int        burst_left  = 0;

  always #4 clk = ~clk;

  grouped_fifo_team_queue_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  team_queue_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_item       (out_item),
    .mismatch_count (mismatch_total),
    .results_owed   (results_owed)
  );

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Issue one command; called just after a rising edge, returns at the accepting edge
  task automatic send_op(input op_t op, input logic [19:0] member,
                         input logic [TEAM_W-1:0] team);
    in_item_t cmd;
    logic     ready;
    cmd.operation  = op;
    cmd.member_id  = member;
    cmd.team_index = team;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start   <= 1'b0;
        in_item <= IN_W'($urandom);
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= cmd;
    do begin
      @(negedge clk);
      ready = !busy;
      @(posedge clk);
    end while (!ready);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  initial begin
    int  enq_pct;
    int  team_lo;
    int  team_hi;
    int  t;
    bit  paused;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty dequeue, field extremes, serving order across teams
    send_op(OP_DEQ, 20'hFFFFF, 4'hF);
    send_op(OP_ENQ, 20'h00000, 4'd0);
    send_op(OP_ENQ, 20'hFFFFF, 4'd15);
    send_op(OP_ENQ, 20'h5A5A5, 4'd0);
    send_op(OP_ENQ, 20'hA5A5A, 4'd9);
    repeat (5) send_op(OP_DEQ, 20'($urandom), TEAM_W'($urandom));
    // a team that empties rejoins the ring behind the others
    send_op(OP_ENQ, 20'h11111, 4'd3);
    send_op(OP_ENQ, 20'h22222, 4'd3);
    send_op(OP_ENQ, 20'h33333, 4'd5);
    send_op(OP_ENQ, 20'h44444, 4'd3);
    repeat (3) send_op(OP_DEQ, 20'h0, 4'd0);
    send_op(OP_ENQ, 20'h55555, 4'd3);
    repeat (3) send_op(OP_DEQ, 20'h0, 4'd0);

    items_sent = 0;
    paused     = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent == 0 || $urandom_range(0, 15) == 0) begin
        // fill one team past its depth to hit drops and pointer wrap
        t = $urandom_range(0, TEAMS - 1);
        repeat (TEAM_DEPTH + $urandom_range(1, 4))
          send_op(OP_ENQ, 20'($urandom), TEAM_W'(t));
      end else if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(20, 90)) send_op(OP_DEQ, 20'($urandom), TEAM_W'($urandom));
      end else begin
        enq_pct = $urandom_range(25, 80);
        team_lo = $urandom_range(0, TEAMS - 1);
        team_hi = $urandom_range(team_lo, TEAMS - 1);
        repeat ($urandom_range(8, 48)) begin
          if ($urandom_range(1, 100) <= enq_pct)
            send_op(OP_ENQ, 20'($urandom), TEAM_W'($urandom_range(team_lo, team_hi)));
          else
            send_op(OP_DEQ, 20'($urandom), TEAM_W'($urandom));
        end
      end
      if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/gftq_pkg.sv
src/grouped_fifo_team_queue_core.sv
src/gftq_checker.sv
verif/team_queue_checker.sv
verif/tb_grouped_fifo_team_queue_core.sv
